[hdl/tc256_pkg.sv]
// shared types and constants for the truecolor to 256-color quantizer
// no dependencies
package tc256_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CCNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam int COLOR_W = 24;
    localparam int PIDX_W = 8;
    localparam int CNT_W = 32;
    localparam int QUOT_W = 7;
    localparam int QSTEP_W = $clog2(QUOT_W);
    localparam int NUM_W = CNT_W + QUOT_W;
    localparam int DEN_W = CNT_W + 1;

    // queue depth must be a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic signed [7:0] PCT_DISABLED = -8'sd1;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [PIDX_W-1:0] quant;
        logic enable;
    } tc_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } back_state_t;

endpackage

[hdl/tc256_front.sv]
// input side: accepts a color, quantizes it and pushes it into the queue
// depends on tc256_pkg
module tc256_front
    import tc256_pkg::*;
(
    input  logic in_valid,
    output logic in_ready,
    input  logic [COLOR_W-1:0] color_rgb,
    input  logic cache_enable,
    input  logic q_full,
    output logic q_push,
    output tc_item_t q_item
);

    localparam logic [7:0] GREY_LOW = 8'd8;
    localparam logic [7:0] GREY_HIGH = 8'd248;
    localparam logic [7:0] GREY_BASE = 8'd232;
    localparam logic [7:0] GREY_MAX_OFF = 8'd23;
    localparam logic [7:0] IDX_BLACK = 8'd16;
    localparam logic [7:0] IDX_WHITE = 8'd231;
    localparam logic [7:0] CUBE_BASE = 8'd16;
    localparam logic [7:0] RECIP_TEN = 8'd205;

    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] q;
        if (v == 8'd255) q = 3'd5;
        else if (v >= 8'd204) q = 3'd4;
        else if (v >= 8'd153) q = 3'd3;
        else if (v >= 8'd102) q = 3'd2;
        else if (v >= 8'd51) q = 3'd1;
        else q = 3'd0;
        return q;
    endfunction

    logic [7:0] r, g, b;
    logic [7:0] grey_x;
    logic [15:0] grey_prod;
    logic [7:0] grey_off;
    logic [7:0] quant;

    assign r = color_rgb[23:16];
    assign g = color_rgb[15:8];
    assign b = color_rgb[7:0];

    // divide by ten through reciprocal, exact for the ramp range
    assign grey_x = r - GREY_LOW;
    assign grey_prod = {8'd0, grey_x} * {8'd0, RECIP_TEN};
    assign grey_off = {3'd0, grey_prod[15:11]};

    always_comb
    begin
        if (r == g && g == b)
        begin
            if (r < GREY_LOW)
                quant = IDX_BLACK;
            else if (r > GREY_HIGH)
                quant = IDX_WHITE;
            else if (grey_off > GREY_MAX_OFF)
                quant = GREY_BASE + GREY_MAX_OFF;
            else
                quant = GREY_BASE + grey_off;
        end
        else
        begin
            quant = CUBE_BASE
                  + 8'd36 * {5'd0, cube_level(r)}
                  + 8'd6 * {5'd0, cube_level(g)}
                  + {5'd0, cube_level(b)};
        end
    end

    assign in_ready = !q_full;
    assign q_push = in_valid && !q_full;
    assign q_item = '{color: color_rgb, quant: quant, enable: cache_enable};

endmodule

[hdl/tc256_queue.sv]
// short queue between front and back
// depends on tc256_pkg
module tc256_queue
    import tc256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tc_item_t push_item,
    input  logic pop,
    output tc_item_t head_item,
    output logic full,
    output logic empty
);

    tc_item_t slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_item = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_item;
    end

endmodule

[hdl/tc256_div.sv]
// restoring divider for the hit percentage, one quotient bit per cycle
// depends on tc256_pkg
module tc256_div
    import tc256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic done,
    output logic [QUOT_W-1:0] quot
);

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [QSTEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [NUM_W:0] shifted_den;
    logic [NUM_W:0] trial;

    assign shifted_den = {{(NUM_W+1-DEN_W){1'b0}}, den_reg} << step_reg;
    assign trial = {1'b0, rem_reg} - shifted_den;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = QSTEP_W'(QUOT_W - 1);
            rem_next = num;
            den_next = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[QUOT_W-2:0], !trial[NUM_W]};
            if (!trial[NUM_W])
                rem_next = trial[NUM_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[hdl/tc256_back.sv]
// back side: memo search and fill, hit and miss counters, result register
// depends on tc256_pkg and tc256_div
module tc256_back
    import tc256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  tc_item_t q_item,
    output logic q_pop,
    output logic out_valid,
    input  logic out_ready,
    output logic [PIDX_W-1:0] palette_index,
    output logic cache_hit,
    output logic signed [7:0] hit_percent
);

    back_state_t state_reg, state_next;

    logic [COLOR_W+PIDX_W-1:0] memo [CACHE_ENTRIES];
    logic [COLOR_W+PIDX_W-1:0] rd_data_reg;
    logic mem_we;

    logic [CCNT_W-1:0] fill_count_reg, fill_count_next;
    logic [CCNT_W-1:0] scan_reg, scan_next;
    logic chk_reg, chk_next;
    logic [CNT_W-1:0] hit_count_reg, hit_count_next;
    logic [CNT_W-1:0] miss_count_reg, miss_count_next;

    logic [COLOR_W-1:0] color_reg, color_next;
    logic [PIDX_W-1:0] quant_reg, quant_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic hit_reg, hit_next;
    logic signed [7:0] pct_reg, pct_next;

    logic out_valid_reg, out_valid_next;
    logic [PIDX_W-1:0] out_idx_reg, out_idx_next;
    logic out_hit_reg, out_hit_next;
    logic signed [7:0] out_pct_reg, out_pct_next;

    logic div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [QUOT_W-1:0] div_quot;
    logic match;

    assign match = chk_reg && (rd_data_reg[COLOR_W+PIDX_W-1:PIDX_W] == color_reg);

    // hits * 100 as shift-and-add
    assign div_num = {1'b0, hit_count_reg, 6'd0} + {2'b0, hit_count_reg, 5'd0}
                   + {5'd0, hit_count_reg, 2'd0};
    assign div_den = {1'b0, hit_count_reg} + {1'b0, miss_count_reg};

    tc256_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_count_next = fill_count_reg;
        scan_next = scan_reg;
        chk_next = 1'b0;
        hit_count_next = hit_count_reg;
        miss_count_next = miss_count_reg;
        color_next = color_reg;
        quant_next = quant_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        pct_next = pct_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next = out_idx_reg;
        out_hit_next = out_hit_reg;
        out_pct_next = out_pct_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    color_next = q_item.color;
                    quant_next = q_item.quant;
                    scan_next = '0;
                    if (q_item.enable)
                        state_next = ST_SEARCH;
                    else
                    begin
                        idx_next = q_item.quant;
                        hit_next = 1'b0;
                        pct_next = PCT_DISABLED;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    idx_next = rd_data_reg[PIDX_W-1:0];
                    hit_next = 1'b1;
                    state_next = ST_UPDATE;
                end
                else if (scan_reg == fill_count_reg)
                begin
                    idx_next = quant_reg;
                    hit_next = 1'b0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    chk_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (hit_reg)
                begin
                    if (hit_count_reg != '1)
                        hit_count_next = hit_count_reg + 1'b1;
                end
                else
                begin
                    if (miss_count_reg != '1)
                        miss_count_next = miss_count_reg + 1'b1;
                    if (fill_count_reg < CCNT_W'(CACHE_ENTRIES))
                    begin
                        mem_we = 1'b1;
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pct_next = $signed({1'b0, div_quot});
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next = idx_reg;
                    out_hit_next = hit_reg;
                    out_pct_next = pct_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_count_reg <= '0;
            chk_reg <= 1'b0;
            hit_count_reg <= '0;
            miss_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_count_reg <= fill_count_next;
            chk_reg <= chk_next;
            hit_count_reg <= hit_count_next;
            miss_count_reg <= miss_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        color_reg <= color_next;
        quant_reg <= quant_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        pct_reg <= pct_next;
        out_idx_reg <= out_idx_next;
        out_hit_reg <= out_hit_next;
        out_pct_reg <= out_pct_next;
    end

    // memo, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            memo[fill_count_reg[CIDX_W-1:0]] <= {color_reg, quant_reg};
        rd_data_reg <= memo[scan_reg[CIDX_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign palette_index = out_idx_reg;
    assign cache_hit = out_hit_reg;
    assign hit_percent = out_pct_reg;

endmodule

[hdl/truecolor_to_256_palette_cached.sv]
// truecolor to 256-color palette quantizer with memo cache, top level
// cache disabled: an item goes from the queue to the result register; enabled: it is also
// searched in the memo, counted and divided, one item at a time; the memo scan reads one
// entry per cycle through a single read port and the percentage takes 7 divider steps
// reset clears counters, fill count and handshake state and sets cache_enable;
// memo contents are not cleared, only filled entries are ever compared
module truecolor_to_256_palette_cached
    import tc256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [COLOR_W-1:0] color_rgb,
    output logic out_valid,
    input  logic out_ready,
    output logic [PIDX_W-1:0] palette_index,
    output logic cache_hit,
    output logic signed [7:0] hit_percent,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    logic cache_enable_reg;
    logic q_full, q_empty, q_push, q_pop;
    tc_item_t push_item, head_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cache_enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            cache_enable_reg <= cfg_data;
    end

    tc256_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .color_rgb    (color_rgb),
        .cache_enable (cache_enable_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    tc256_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tc256_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .palette_index (palette_index),
        .cache_hit     (cache_hit),
        .hit_percent   (hit_percent)
    );

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !q_empty)
        else $error("accepted beat did not reach the queue");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> palette_index >= 8'd16)
        else $error("palette index below cube base");

    a_hit_has_percent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cache_hit |-> hit_percent != PCT_DISABLED)
        else $error("cache hit reported with disabled percentage");

endmodule
